// File: rtl/core/arpc_pkg.sv
// Shared types and constants for the ARP resolution cache.
// Used by arpc_ctrl, arpc_dp and arp_cache_with_pending_queue; no dependencies.
`default_nettype none

package arpc_pkg;

	// table sizes
	localparam int CACHE_ENTRIES   = 16;
	localparam int REQUEST_ENTRIES = 8;
	localparam int PENDING_ENTRIES = 16;
	localparam int HANDLE_BITS     = 16;

	localparam int CI_W    = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int RI_W    = (REQUEST_ENTRIES > 1) ? $clog2(REQUEST_ENTRIES) : 1;
	localparam int PI_W    = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
	localparam int PCNT_W  = $clog2(PENDING_ENTRIES + 1);
	localparam int SCAN_W  = (CI_W > RI_W) ? CI_W : RI_W;

	// command codes
	localparam logic [1:0] CMD_SEND = 2'd0;
	localparam logic [1:0] CMD_RECV = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;
	localparam logic [1:0] CMD_RSVD = 2'd3;

	// result kinds
	localparam logic [2:0] KIND_IPV4    = 3'd0;
	localparam logic [2:0] KIND_ARPREQ  = 3'd1;
	localparam logic [2:0] KIND_ARPREP  = 3'd2;
	localparam logic [2:0] KIND_DELIVER = 3'd3;
	localparam logic [2:0] KIND_DROP    = 3'd4;

	// protocol constants
	localparam logic [7:0]  TCP_PROTOCOL  = 8'd6;
	localparam logic [47:0] BROADCAST_MAC = 48'hFFFF_FFFF_FFFF;
	localparam logic [15:0] ETH_IPV4      = 16'h0800;
	localparam logic [15:0] ETH_ARP       = 16'h0806;
	localparam logic [15:0] OP_REQUEST    = 16'd1;
	localparam logic [15:0] OP_REPLY      = 16'd2;

	// configuration register indexes
	localparam logic [1:0] REG_OWN_MAC  = 2'd0;
	localparam logic [1:0] REG_OWN_IP   = 2'd1;
	localparam logic [1:0] REG_LIFETIME = 2'd2;
	localparam logic [1:0] REG_TIMEOUT  = 2'd3;

	localparam logic [31:0] LIFETIME_RST = 32'd30000;
	localparam logic [31:0] TIMEOUT_RST  = 32'd5000;

	typedef struct packed {
		logic [1:0]             cmd;
		logic [HANDLE_BITS-1:0] item_handle;
		logic [31:0]            gateway_ip;
		logic [7:0]             ip_protocol;
		logic [47:0]            frame_dst_mac;
		logic [15:0]            frame_ethertype;
		logic                   payload_ok;
		logic [15:0]            arp_opcode;
		logic [31:0]            arp_sender_ip;
		logic [47:0]            arp_sender_mac;
		logic [31:0]            arp_target_ip_in;
		logic [31:0]            elapsed_ms;
	} in_item_t;

	typedef struct packed {
		logic [2:0]             out_kind;
		logic [47:0]            out_dst_mac;
		logic [HANDLE_BITS-1:0] out_handle;
		logic [31:0]            out_arp_target_ip;
		logic [47:0]            out_arp_target_mac;
		logic                   out_last;
	} out_item_t;

	// datapath operations
	typedef enum logic [4:0] {
		DP_NOP,
		DP_LATCH,
		DP_CLR,
		DP_CHIT,
		DP_RCHK,
		DP_PADD,
		DP_REQADD,
		DP_EMIT_HIT,
		DP_EMIT_DROP,
		DP_EMIT_DLV,
		DP_EMIT_RPLY,
		DP_LSCAN,
		DP_LWRITE,
		DP_PSTART,
		DP_PSTEP,
		DP_PEND,
		DP_TCACHE,
		DP_TREQ,
		DP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t            op;
		logic [SCAN_W-1:0] idx;
		logic [PI_W-1:0]   rank;
		logic              rel;
	} dp_cmd_t;

	typedef struct packed {
		logic              can_emit;
		logic [1:0]        cmd;
		logic              proto_ok;
		logic              dst_ok;
		logic              is_ipv4;
		logic              is_arp;
		logic              pay_ok;
		logic              reply_ok;
		logic              hit;
		logic              pend_full;
		logic              outst;
		logic              req_full;
		logic              c_exp;
		logic              r_exp;
		logic [PCNT_W-1:0] pend_cnt;
	} dp_sts_t;

	typedef enum logic [15:0] {
		ST_IDLE   = 16'b0000_0000_0000_0001,
		ST_DECODE = 16'b0000_0000_0000_0010,
		ST_CSCAN  = 16'b0000_0000_0000_0100,
		ST_SDEC   = 16'b0000_0000_0000_1000,
		ST_RSCAN  = 16'b0000_0000_0001_0000,
		ST_RDEC   = 16'b0000_0000_0010_0000,
		ST_EMIT   = 16'b0000_0000_0100_0000,
		ST_LSCAN  = 16'b0000_0000_1000_0000,
		ST_LWRITE = 16'b0000_0001_0000_0000,
		ST_PSTART = 16'b0000_0010_0000_0000,
		ST_PSTEP  = 16'b0000_0100_0000_0000,
		ST_PEND   = 16'b0000_1000_0000_0000,
		ST_TCACHE = 16'b0001_0000_0000_0000,
		ST_TREQ   = 16'b0010_0000_0000_0000,
		ST_TNEXT  = 16'b0100_0000_0000_0000,
		ST_FIN    = 16'b1000_0000_0000_0000
	} state_t;

endpackage

`default_nettype wire

// File: rtl/core/arp_cache_with_pending_queue.sv
// ARP address resolution cache with pending datagram list.
// Top level: joins arpc_ctrl and arpc_dp. Depends on arpc_pkg.
//
// Usage: items enter on in_valid/in_ready (send, receive or tick command);
// results leave on out_valid/out_ready, out_last marking the final result
// of an item. Configuration is written through cfg_we/cfg_index/cfg_data;
// the user must do so only while the block is idle, since the block itself
// does not enforce it. One item is worked at a time: a TCP send scans the
// cache and, on a miss with room in the pending list, the request table;
// a receive of ARP sends any reply first, then runs the learn scan and
// one step per queued handle; a tick visits every cache and request entry
// and, for every entry that expires, passes over the pending list.
// The sequencer walks each table one entry at a time, so table depth sets
// how long an item takes. Results pass through a one-deep staging register
// and an output register; when the receiver stalls, the walk pauses on the
// next result, and a new item is taken once the last result sits in the
// output register. Reset clears all valid bits and counts; tables need no
// clearing.
`default_nettype none

module arp_cache_with_pending_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [47:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire arpc_pkg::in_item_t in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output arpc_pkg::out_item_t     out_data
);

	arpc_pkg::dp_cmd_t cmd;
	arpc_pkg::dp_sts_t sts;

	arpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	arpc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// File: rtl/core/arpc_dp.sv
// Datapath of the ARP resolution cache: tables, item register, scan flags,
// result staging and output register. Depends on arpc_pkg.
`default_nettype none

module arpc_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [47:0]        cfg_data,
	input  wire arpc_pkg::in_item_t in_data,
	input  wire arpc_pkg::dp_cmd_t  cmd,
	output arpc_pkg::dp_sts_t       sts,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output arpc_pkg::out_item_t     out_data
);

	localparam int CE = arpc_pkg::CACHE_ENTRIES;
	localparam int RE = arpc_pkg::REQUEST_ENTRIES;
	localparam int PE = arpc_pkg::PENDING_ENTRIES;
	localparam int CI_W = arpc_pkg::CI_W;
	localparam int RI_W = arpc_pkg::RI_W;
	localparam int PI_W = arpc_pkg::PI_W;
	localparam int PCNT_W = arpc_pkg::PCNT_W;
	localparam int HB = arpc_pkg::HANDLE_BITS;

	// configuration
	logic [47:0] own_mac_q;
	logic [31:0] own_ip_q, lifetime_q, timeout_q;

	arpc_pkg::in_item_t item_q;

	// tables
	logic [CE-1:0] cache_vld_q;
	logic [31:0]   cache_ip_q   [CE];
	logic [47:0]   cache_mac_q  [CE];
	logic [31:0]   cache_life_q [CE];
	logic [RE-1:0] req_vld_q;
	logic [31:0]   req_ip_q   [RE];
	logic [31:0]   req_left_q [RE];
	logic [PE-1:0] pend_vld_q;
	logic [31:0]   pend_ip_q  [PE];
	logic [HB-1:0] pend_hdl_q [PE];
	logic [PI_W-1:0] pend_age_q [PE];
	logic [PCNT_W-1:0] pend_cnt_q;

	// scan and pass state
	logic            hit_q, outst_q, lmatch_q;
	logic [CI_W-1:0] hit_idx_q, lmatch_idx_q, lmin_idx_q;
	logic [31:0]     lmin_val_q;
	logic [31:0]     key_ip_q;
	logic [PE-1:0]   visited_q;
	logic [PCNT_W-1:0] keep_cnt_q;

	// staging and output
	logic                st_vld_q, out_vld_q;
	arpc_pkg::out_item_t st_q, out_q;

	function automatic logic [CI_W-1:0] first_zero_c(input logic [CE-1:0] v);
		logic [CI_W-1:0] r;
		r = '0;
		for (int i = CE - 1; i >= 0; i--)
			if (!v[i]) r = CI_W'(i);
		return r;
	endfunction

	function automatic logic [RI_W-1:0] first_zero_r(input logic [RE-1:0] v);
		logic [RI_W-1:0] r;
		r = '0;
		for (int i = RE - 1; i >= 0; i--)
			if (!v[i]) r = RI_W'(i);
		return r;
	endfunction

	function automatic logic [PI_W-1:0] first_zero_p(input logic [PE-1:0] v);
		logic [PI_W-1:0] r;
		r = '0;
		for (int i = PE - 1; i >= 0; i--)
			if (!v[i]) r = PI_W'(i);
		return r;
	endfunction

	logic [CI_W-1:0] ci, free_c, slot_c;
	logic [RI_W-1:0] ri, free_r;
	logic [PI_W-1:0] free_p, pe;
	logic            c_match, l_match, r_match, c_exp, r_exp, pe_hit;
	logic            out_free, can_emit, emit_en, finish_en, rel_emit;
	arpc_pkg::out_item_t emit_item;

	assign ci = cmd.idx[CI_W-1:0];
	assign ri = cmd.idx[RI_W-1:0];
	assign free_c = first_zero_c(cache_vld_q);
	assign free_r = first_zero_r(req_vld_q);
	assign free_p = first_zero_p(pend_vld_q);

	// compares on the entry under the scan index
	assign c_match = cache_vld_q[ci] && (cache_ip_q[ci] == item_q.gateway_ip);
	assign l_match = cache_vld_q[ci] && (cache_ip_q[ci] == item_q.arp_sender_ip);
	assign r_match = req_vld_q[ri] && (req_ip_q[ri] == item_q.gateway_ip);
	assign c_exp   = cache_vld_q[ci] && !(cache_life_q[ci] > item_q.elapsed_ms);
	assign r_exp   = req_vld_q[ri] && !(req_left_q[ri] > item_q.elapsed_ms);

	// learned entry goes to its old slot, else a free one, else the shortest-lived
	always_comb begin
		if (lmatch_q) begin
			slot_c = lmatch_idx_q;
		end else if (!(&cache_vld_q)) begin
			slot_c = free_c;
		end else begin
			slot_c = lmin_idx_q;
		end
	end

	// locate the unvisited pending entry holding the current rank
	always_comb begin
		pe = '0;
		for (int j = 0; j < PE; j++)
			if (pend_vld_q[j] && !visited_q[j] && (pend_age_q[j] == cmd.rank))
				pe = PI_W'(j);
	end
	assign pe_hit = pend_ip_q[pe] == key_ip_q;

	assign out_free = !out_vld_q || out_ready;
	assign can_emit = !st_vld_q || out_free;
	assign rel_emit = (cmd.op == arpc_pkg::DP_PSTEP) && cmd.rel && pe_hit;
	assign finish_en = (cmd.op == arpc_pkg::DP_FINISH) && st_vld_q;

	// build the result for this operation
	always_comb begin
		emit_item = '0;
		emit_en   = 1'b1;
		unique case (cmd.op)
			arpc_pkg::DP_EMIT_HIT: begin
				emit_item.out_kind    = arpc_pkg::KIND_IPV4;
				emit_item.out_dst_mac = cache_mac_q[hit_idx_q];
				emit_item.out_handle  = item_q.item_handle;
			end
			arpc_pkg::DP_EMIT_DROP: begin
				emit_item.out_kind   = arpc_pkg::KIND_DROP;
				emit_item.out_handle = item_q.item_handle;
			end
			arpc_pkg::DP_EMIT_DLV: begin
				emit_item.out_kind   = arpc_pkg::KIND_DELIVER;
				emit_item.out_handle = item_q.item_handle;
			end
			arpc_pkg::DP_EMIT_RPLY: begin
				emit_item.out_kind           = arpc_pkg::KIND_ARPREP;
				emit_item.out_dst_mac        = item_q.arp_sender_mac;
				emit_item.out_arp_target_ip  = item_q.arp_sender_ip;
				emit_item.out_arp_target_mac = item_q.arp_sender_mac;
			end
			arpc_pkg::DP_REQADD: begin
				emit_item.out_kind          = arpc_pkg::KIND_ARPREQ;
				emit_item.out_dst_mac       = arpc_pkg::BROADCAST_MAC;
				emit_item.out_arp_target_ip = item_q.gateway_ip;
			end
			arpc_pkg::DP_PSTEP: begin
				emit_item.out_kind    = arpc_pkg::KIND_IPV4;
				emit_item.out_dst_mac = item_q.arp_sender_mac;
				emit_item.out_handle  = pend_hdl_q[pe];
				emit_en               = rel_emit;
			end
			default: begin
				emit_en = 1'b0;
			end
		endcase
	end

	// control state: valid bits, flags, counts, configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q   <= '0;
			own_ip_q    <= '0;
			lifetime_q  <= arpc_pkg::LIFETIME_RST;
			timeout_q   <= arpc_pkg::TIMEOUT_RST;
			cache_vld_q <= '0;
			req_vld_q   <= '0;
			pend_vld_q  <= '0;
			pend_cnt_q  <= '0;
			hit_q       <= 1'b0;
			outst_q     <= 1'b0;
			lmatch_q    <= 1'b0;
			visited_q   <= '0;
			keep_cnt_q  <= '0;
			st_vld_q    <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					arpc_pkg::REG_OWN_MAC:  own_mac_q  <= cfg_data;
					arpc_pkg::REG_OWN_IP:   own_ip_q   <= cfg_data[31:0];
					arpc_pkg::REG_LIFETIME: lifetime_q <= cfg_data[31:0];
					arpc_pkg::REG_TIMEOUT:  timeout_q  <= cfg_data[31:0];
					default: ;
				endcase
			end
			unique case (cmd.op)
				arpc_pkg::DP_CLR: begin
					hit_q    <= 1'b0;
					outst_q  <= 1'b0;
					lmatch_q <= 1'b0;
				end
				arpc_pkg::DP_CHIT: begin
					if (c_match && !hit_q) hit_q <= 1'b1;
				end
				arpc_pkg::DP_RCHK: begin
					if (r_match) outst_q <= 1'b1;
				end
				arpc_pkg::DP_PADD: begin
					pend_vld_q[free_p] <= 1'b1;
					pend_cnt_q         <= pend_cnt_q + PCNT_W'(1);
				end
				arpc_pkg::DP_REQADD: begin
					pend_vld_q[free_p] <= 1'b1;
					pend_cnt_q         <= pend_cnt_q + PCNT_W'(1);
					req_vld_q[free_r]  <= 1'b1;
				end
				arpc_pkg::DP_LSCAN: begin
					if (l_match && !lmatch_q) lmatch_q <= 1'b1;
				end
				arpc_pkg::DP_LWRITE: begin
					cache_vld_q[slot_c] <= 1'b1;
				end
				arpc_pkg::DP_PSTART: begin
					visited_q  <= '0;
					keep_cnt_q <= '0;
				end
				arpc_pkg::DP_PSTEP: begin
					visited_q[pe] <= 1'b1;
					if (pe_hit) begin
						pend_vld_q[pe] <= 1'b0;
					end else begin
						keep_cnt_q <= keep_cnt_q + PCNT_W'(1);
					end
				end
				arpc_pkg::DP_PEND: begin
					pend_cnt_q <= keep_cnt_q;
				end
				arpc_pkg::DP_TCACHE: begin
					if (c_exp) cache_vld_q[ci] <= 1'b0;
				end
				arpc_pkg::DP_TREQ: begin
					if (r_exp) req_vld_q[ri] <= 1'b0;
				end
				default: ;
			endcase
			// staging and output handshake
			if ((emit_en || finish_en) && st_vld_q) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			if (emit_en) begin
				st_vld_q <= 1'b1;
			end else if (finish_en) begin
				st_vld_q <= 1'b0;
			end
		end
	end

	// payload state: table contents, item, scan indexes, results
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			arpc_pkg::DP_LATCH: begin
				item_q <= in_data;
			end
			arpc_pkg::DP_CHIT: begin
				if (c_match && !hit_q) hit_idx_q <= ci;
			end
			arpc_pkg::DP_PADD: begin
				pend_ip_q[free_p]  <= item_q.gateway_ip;
				pend_hdl_q[free_p] <= item_q.item_handle;
				pend_age_q[free_p] <= pend_cnt_q[PI_W-1:0];
			end
			arpc_pkg::DP_REQADD: begin
				pend_ip_q[free_p]  <= item_q.gateway_ip;
				pend_hdl_q[free_p] <= item_q.item_handle;
				pend_age_q[free_p] <= pend_cnt_q[PI_W-1:0];
				req_ip_q[free_r]   <= item_q.gateway_ip;
				req_left_q[free_r] <= timeout_q;
			end
			arpc_pkg::DP_LSCAN: begin
				if (l_match && !lmatch_q) lmatch_idx_q <= ci;
				if ((ci == '0) || (cache_life_q[ci] < lmin_val_q)) begin
					lmin_idx_q <= ci;
					lmin_val_q <= cache_life_q[ci];
				end
			end
			arpc_pkg::DP_LWRITE: begin
				cache_ip_q[slot_c]   <= item_q.arp_sender_ip;
				cache_mac_q[slot_c]  <= item_q.arp_sender_mac;
				cache_life_q[slot_c] <= lifetime_q;
				key_ip_q             <= item_q.arp_sender_ip;
			end
			arpc_pkg::DP_PSTEP: begin
				if (!pe_hit) pend_age_q[pe] <= keep_cnt_q[PI_W-1:0];
			end
			arpc_pkg::DP_TCACHE: begin
				if (c_exp) begin
					key_ip_q <= cache_ip_q[ci];
				end else if (cache_vld_q[ci]) begin
					cache_life_q[ci] <= cache_life_q[ci] - item_q.elapsed_ms;
				end
			end
			arpc_pkg::DP_TREQ: begin
				if (r_exp) begin
					key_ip_q <= req_ip_q[ri];
				end else if (req_vld_q[ri]) begin
					req_left_q[ri] <= req_left_q[ri] - item_q.elapsed_ms;
				end
			end
			default: ;
		endcase
		if (emit_en) st_q <= emit_item;
		// advance the staged result; out_last is the low bit of the item
		if ((emit_en || finish_en) && st_vld_q) begin
			out_q <= {st_q[$bits(st_q)-1:1], finish_en};
		end
	end

	// status to the controller
	always_comb begin
		sts          = '0;
		sts.can_emit = can_emit;
		sts.cmd      = item_q.cmd;
		sts.proto_ok = item_q.ip_protocol == arpc_pkg::TCP_PROTOCOL;
		sts.dst_ok   = (item_q.frame_dst_mac == arpc_pkg::BROADCAST_MAC) ||
		               (item_q.frame_dst_mac == own_mac_q);
		sts.is_ipv4  = item_q.frame_ethertype == arpc_pkg::ETH_IPV4;
		sts.is_arp   = item_q.frame_ethertype == arpc_pkg::ETH_ARP;
		sts.pay_ok   = item_q.payload_ok;
		sts.reply_ok = (item_q.arp_opcode == arpc_pkg::OP_REQUEST) &&
		               (item_q.arp_target_ip_in == own_ip_q);
		sts.hit       = hit_q;
		sts.pend_full = &pend_vld_q;
		sts.outst     = outst_q;
		sts.req_full  = &req_vld_q;
		sts.c_exp     = c_exp;
		sts.r_exp     = r_exp;
		sts.pend_cnt  = pend_cnt_q;
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// File: rtl/core/arpc_ctrl.sv
// Controller of the ARP resolution cache: sequences table scans, learning,
// pending-list passes and tick sweeps. Depends on arpc_pkg.
`default_nettype none

module arpc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire arpc_pkg::dp_sts_t sts,
	output arpc_pkg::dp_cmd_t      cmd
);

	localparam int SCAN_W = arpc_pkg::SCAN_W;
	localparam int PI_W = arpc_pkg::PI_W;
	localparam int PCNT_W = arpc_pkg::PCNT_W;
	localparam logic [SCAN_W-1:0] C_LAST = SCAN_W'(arpc_pkg::CACHE_ENTRIES - 1);
	localparam logic [SCAN_W-1:0] R_LAST = SCAN_W'(arpc_pkg::REQUEST_ENTRIES - 1);

	arpc_pkg::state_t  state_q, state_d;
	logic [SCAN_W-1:0] idx_q, idx_d;
	logic [PI_W-1:0]   rank_q, rank_d;
	logic              rel_q, rel_d, tph_q, tph_d;
	arpc_pkg::dp_op_t  emit_op_q, emit_op_d;
	arpc_pkg::dp_op_t  op;
	logic              rank_last;

	assign rank_last = (PCNT_W'(rank_q) + PCNT_W'(1)) == sts.pend_cnt;

	// next state and datapath operation
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		rank_d    = rank_q;
		rel_d     = rel_q;
		tph_d     = tph_q;
		emit_op_d = emit_op_q;
		op        = arpc_pkg::DP_NOP;
		unique case (state_q)
			arpc_pkg::ST_IDLE: begin
				if (in_valid) begin
					op      = arpc_pkg::DP_LATCH;
					state_d = arpc_pkg::ST_DECODE;
				end
			end
			arpc_pkg::ST_DECODE: begin
				op      = arpc_pkg::DP_CLR;
				idx_d   = '0;
				state_d = arpc_pkg::ST_FIN;
				priority if (sts.cmd == arpc_pkg::CMD_SEND) begin
					if (sts.proto_ok) state_d = arpc_pkg::ST_CSCAN;
				end else if (sts.cmd == arpc_pkg::CMD_RECV) begin
					if (sts.dst_ok && sts.pay_ok && sts.is_ipv4) begin
						emit_op_d = arpc_pkg::DP_EMIT_DLV;
						state_d   = arpc_pkg::ST_EMIT;
					end else if (sts.dst_ok && sts.pay_ok && sts.is_arp) begin
						if (sts.reply_ok) begin
							emit_op_d = arpc_pkg::DP_EMIT_RPLY;
							state_d   = arpc_pkg::ST_EMIT;
						end else begin
							state_d = arpc_pkg::ST_LSCAN;
						end
					end
				end else if (sts.cmd == arpc_pkg::CMD_TICK) begin
					tph_d   = 1'b0;
					state_d = arpc_pkg::ST_TCACHE;
				end else begin
					state_d = arpc_pkg::ST_FIN;
				end
			end
			arpc_pkg::ST_CSCAN: begin
				op = arpc_pkg::DP_CHIT;
				if (idx_q == C_LAST) begin
					state_d = arpc_pkg::ST_SDEC;
				end else begin
					idx_d = idx_q + SCAN_W'(1);
				end
			end
			arpc_pkg::ST_SDEC: begin
				idx_d = '0;
				priority if (sts.hit) begin
					emit_op_d = arpc_pkg::DP_EMIT_HIT;
					state_d   = arpc_pkg::ST_EMIT;
				end else if (sts.pend_full) begin
					emit_op_d = arpc_pkg::DP_EMIT_DROP;
					state_d   = arpc_pkg::ST_EMIT;
				end else begin
					state_d = arpc_pkg::ST_RSCAN;
				end
			end
			arpc_pkg::ST_RSCAN: begin
				op = arpc_pkg::DP_RCHK;
				if (idx_q == R_LAST) begin
					state_d = arpc_pkg::ST_RDEC;
				end else begin
					idx_d = idx_q + SCAN_W'(1);
				end
			end
			arpc_pkg::ST_RDEC: begin
				priority if (sts.outst) begin
					op      = arpc_pkg::DP_PADD;
					state_d = arpc_pkg::ST_FIN;
				end else if (sts.req_full) begin
					emit_op_d = arpc_pkg::DP_EMIT_DROP;
					state_d   = arpc_pkg::ST_EMIT;
				end else begin
					emit_op_d = arpc_pkg::DP_REQADD;
					state_d   = arpc_pkg::ST_EMIT;
				end
			end
			arpc_pkg::ST_EMIT: begin
				if (sts.can_emit) begin
					op = emit_op_q;
					if (emit_op_q == arpc_pkg::DP_EMIT_RPLY) begin
						idx_d   = '0;
						state_d = arpc_pkg::ST_LSCAN;
					end else begin
						state_d = arpc_pkg::ST_FIN;
					end
				end
			end
			arpc_pkg::ST_LSCAN: begin
				op = arpc_pkg::DP_LSCAN;
				if (idx_q == C_LAST) begin
					state_d = arpc_pkg::ST_LWRITE;
				end else begin
					idx_d = idx_q + SCAN_W'(1);
				end
			end
			arpc_pkg::ST_LWRITE: begin
				op      = arpc_pkg::DP_LWRITE;
				rel_d   = 1'b1;
				state_d = arpc_pkg::ST_PSTART;
			end
			arpc_pkg::ST_PSTART: begin
				op     = arpc_pkg::DP_PSTART;
				rank_d = '0;
				if (sts.pend_cnt == '0) begin
					state_d = arpc_pkg::ST_PEND;
				end else begin
					state_d = arpc_pkg::ST_PSTEP;
				end
			end
			arpc_pkg::ST_PSTEP: begin
				if (!rel_q || sts.can_emit) begin
					op = arpc_pkg::DP_PSTEP;
					if (rank_last) begin
						state_d = arpc_pkg::ST_PEND;
					end else begin
						rank_d = rank_q + PI_W'(1);
					end
				end
			end
			arpc_pkg::ST_PEND: begin
				op      = arpc_pkg::DP_PEND;
				state_d = rel_q ? arpc_pkg::ST_FIN : arpc_pkg::ST_TNEXT;
			end
			arpc_pkg::ST_TCACHE: begin
				op    = arpc_pkg::DP_TCACHE;
				rel_d = 1'b0;
				state_d = sts.c_exp ? arpc_pkg::ST_PSTART : arpc_pkg::ST_TNEXT;
			end
			arpc_pkg::ST_TREQ: begin
				op    = arpc_pkg::DP_TREQ;
				rel_d = 1'b0;
				state_d = sts.r_exp ? arpc_pkg::ST_PSTART : arpc_pkg::ST_TNEXT;
			end
			arpc_pkg::ST_TNEXT: begin
				if (!tph_q) begin
					if (idx_q == C_LAST) begin
						idx_d   = '0;
						tph_d   = 1'b1;
						state_d = arpc_pkg::ST_TREQ;
					end else begin
						idx_d   = idx_q + SCAN_W'(1);
						state_d = arpc_pkg::ST_TCACHE;
					end
				end else begin
					if (idx_q == R_LAST) begin
						state_d = arpc_pkg::ST_FIN;
					end else begin
						idx_d   = idx_q + SCAN_W'(1);
						state_d = arpc_pkg::ST_TREQ;
					end
				end
			end
			arpc_pkg::ST_FIN: begin
				if (sts.can_emit) begin
					op      = arpc_pkg::DP_FINISH;
					state_d = arpc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = arpc_pkg::ST_IDLE;
			end
		endcase
	end

	// hold state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= arpc_pkg::ST_IDLE;
			idx_q     <= '0;
			rank_q    <= '0;
			rel_q     <= 1'b0;
			tph_q     <= 1'b0;
			emit_op_q <= arpc_pkg::DP_NOP;
		end else begin
			state_q   <= state_d;
			idx_q     <= idx_d;
			rank_q    <= rank_d;
			rel_q     <= rel_d;
			tph_q     <= tph_d;
			emit_op_q <= emit_op_d;
		end
	end

	assign in_ready = state_q == arpc_pkg::ST_IDLE;
	assign cmd.op   = op;
	assign cmd.idx  = idx_q;
	assign cmd.rank = rank_q;
	assign cmd.rel  = rel_q;

endmodule

`default_nettype wire

// File: tb/sv/arpc_scoreboard.sv
// Scoreboard for the ARP resolution cache: tracks register writes, predicts
// the results of each accepted item and compares them with the output channel.
// Depends on arpc_pkg.
`default_nettype none

module arpc_scoreboard
	import arpc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [47:0] cfg_data,
	input  wire logic      in_valid,
	input  wire logic      in_ready,
	input  wire in_item_t  in_data,
	input  wire logic      out_valid,
	input  wire logic      out_ready,
	input  wire out_item_t out_data,
	input  wire logic      run_done,
	output int             errors,
	output int             waiting
);

	// register copies
	logic [47:0] mac_reg;
	logic [31:0] ip_reg, life_reg, tmo_reg;

	// table copies
	bit                     arp_ok [CACHE_ENTRIES];
	logic [31:0]            arp_ip [CACHE_ENTRIES];
	logic [47:0]            arp_mac [CACHE_ENTRIES];
	logic [31:0]            arp_life [CACHE_ENTRIES];
	bit                     req_ok [REQUEST_ENTRIES];
	logic [31:0]            req_ip [REQUEST_ENTRIES];
	logic [31:0]            req_left [REQUEST_ENTRIES];
	bit                     hold_ok [PENDING_ENTRIES];
	logic [31:0]            hold_ip [PENDING_ENTRIES];
	logic [HANDLE_BITS-1:0] hold_h [PENDING_ENTRIES];
	int                     hold_rank [PENDING_ENTRIES];

	out_item_t due_results[$];
	out_item_t item_results[$];
	bit        done_seen;

	task automatic report(input string msg);
		$display("arpc_scoreboard: mismatch: %s", msg);
		errors++;
	endtask

	function automatic void add_result(input logic [2:0] kind, input logic [47:0] dst,
			input logic [HANDLE_BITS-1:0] h, input logic [31:0] tip, input logic [47:0] tmac);
		out_item_t r;
		r.out_kind = kind;
		r.out_dst_mac = dst;
		r.out_handle = h;
		r.out_arp_target_ip = tip;
		r.out_arp_target_mac = tmac;
		r.out_last = 1'b0;
		item_results.push_back(r);
	endfunction

	function automatic void drop_held(input int i);
		int a;
		a = hold_rank[i];
		hold_ok[i] = 0;
		for (int j = 0; j < PENDING_ENTRIES; j++)
			if (hold_ok[j] && hold_rank[j] > a) hold_rank[j]--;
	endfunction

	function automatic int oldest_held(input logic [31:0] ip);
		int best;
		best = -1;
		for (int i = 0; i < PENDING_ENTRIES; i++)
			if (hold_ok[i] && hold_ip[i] == ip && (best < 0 || hold_rank[i] < hold_rank[best]))
				best = i;
		return best;
	endfunction

	function automatic void purge_held(input logic [31:0] ip);
		int i;
		i = oldest_held(ip);
		while (i >= 0) begin
			drop_held(i);
			i = oldest_held(ip);
		end
	endfunction

	function automatic void learn_mac(input logic [31:0] ip, input logic [47:0] mac);
		int slot;
		slot = -1;
		for (int i = 0; i < CACHE_ENTRIES && slot < 0; i++)
			if (arp_ok[i] && arp_ip[i] == ip) slot = i;
		for (int i = 0; i < CACHE_ENTRIES && slot < 0; i++)
			if (!arp_ok[i]) slot = i;
		if (slot < 0) begin
			slot = 0;
			for (int i = 1; i < CACHE_ENTRIES; i++)
				if (arp_life[i] < arp_life[slot]) slot = i;
		end
		arp_ok[slot] = 1;
		arp_ip[slot] = ip;
		arp_mac[slot] = mac;
		arp_life[slot] = life_reg;
	endfunction

	function automatic void resolve_send(input in_item_t it);
		int free_p, cnt, free_r;
		bit outst;
		free_p = -1;
		cnt = 0;
		free_r = -1;
		outst = 0;
		if (it.ip_protocol != TCP_PROTOCOL) return;
		for (int i = 0; i < CACHE_ENTRIES; i++)
			if (arp_ok[i] && arp_ip[i] == it.gateway_ip) begin
				add_result(KIND_IPV4, arp_mac[i], it.item_handle, '0, '0);
				return;
			end
		for (int i = 0; i < PENDING_ENTRIES; i++) begin
			if (hold_ok[i]) cnt++;
			else if (free_p < 0) free_p = i;
		end
		if (free_p < 0) begin
			add_result(KIND_DROP, '0, it.item_handle, '0, '0);
			return;
		end
		for (int i = 0; i < REQUEST_ENTRIES; i++) begin
			if (req_ok[i] && req_ip[i] == it.gateway_ip) outst = 1;
			if (!req_ok[i] && free_r < 0) free_r = i;
		end
		if (!outst) begin
			if (free_r < 0) begin
				add_result(KIND_DROP, '0, it.item_handle, '0, '0);
				return;
			end
			req_ok[free_r] = 1;
			req_ip[free_r] = it.gateway_ip;
			req_left[free_r] = tmo_reg;
			add_result(KIND_ARPREQ, BROADCAST_MAC, '0, it.gateway_ip, '0);
		end
		hold_ok[free_p] = 1;
		hold_ip[free_p] = it.gateway_ip;
		hold_h[free_p] = it.item_handle;
		hold_rank[free_p] = cnt;
	endfunction

	function automatic void resolve_recv(input in_item_t it);
		int i;
		if (it.frame_dst_mac != BROADCAST_MAC && it.frame_dst_mac != mac_reg) return;
		if (it.frame_ethertype == ETH_IPV4) begin
			if (it.payload_ok) add_result(KIND_DELIVER, '0, it.item_handle, '0, '0);
			return;
		end
		if (it.frame_ethertype != ETH_ARP || !it.payload_ok) return;
		if (it.arp_opcode == OP_REQUEST && it.arp_target_ip_in == ip_reg)
			add_result(KIND_ARPREP, it.arp_sender_mac, '0, it.arp_sender_ip,
				it.arp_sender_mac);
		learn_mac(it.arp_sender_ip, it.arp_sender_mac);
		// release queued handles for the sender, oldest first
		i = oldest_held(it.arp_sender_ip);
		while (i >= 0) begin
			add_result(KIND_IPV4, it.arp_sender_mac, hold_h[i], '0, '0);
			drop_held(i);
			i = oldest_held(it.arp_sender_ip);
		end
	endfunction

	function automatic void resolve_tick(input logic [31:0] el);
		for (int i = 0; i < CACHE_ENTRIES; i++) begin
			if (!arp_ok[i]) continue;
			if (arp_life[i] > el) arp_life[i] -= el;
			else begin
				arp_ok[i] = 0;
				purge_held(arp_ip[i]);
			end
		end
		for (int i = 0; i < REQUEST_ENTRIES; i++) begin
			if (!req_ok[i]) continue;
			if (req_left[i] > el) req_left[i] -= el;
			else begin
				req_ok[i] = 0;
				purge_held(req_ip[i]);
			end
		end
	endfunction

	// track registers, predict accepted items and check results
	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_r;
		if (!arst_n) begin
			mac_reg = '0;
			ip_reg = '0;
			life_reg = LIFETIME_RST;
			tmo_reg = TIMEOUT_RST;
			foreach (arp_ok[i]) arp_ok[i] = 0;
			foreach (req_ok[i]) req_ok[i] = 0;
			foreach (hold_ok[i]) hold_ok[i] = 0;
			due_results.delete();
			errors = 0;
			waiting = 0;
			done_seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) report("result with nothing expected");
				else begin
					exp_r = due_results.pop_front();
					if (out_data.out_kind !== exp_r.out_kind)
						report($sformatf("kind %0d, want %0d", out_data.out_kind, exp_r.out_kind));
					if (out_data.out_dst_mac !== exp_r.out_dst_mac)
						report($sformatf("dst_mac %h, want %h", out_data.out_dst_mac,
							exp_r.out_dst_mac));
					if (out_data.out_handle !== exp_r.out_handle)
						report($sformatf("handle %h, want %h", out_data.out_handle,
							exp_r.out_handle));
					if (out_data.out_arp_target_ip !== exp_r.out_arp_target_ip)
						report($sformatf("target_ip %h, want %h", out_data.out_arp_target_ip,
							exp_r.out_arp_target_ip));
					if (out_data.out_arp_target_mac !== exp_r.out_arp_target_mac)
						report($sformatf("target_mac %h, want %h", out_data.out_arp_target_mac,
							exp_r.out_arp_target_mac));
					if (out_data.out_last !== exp_r.out_last)
						report($sformatf("last %b, want %b", out_data.out_last, exp_r.out_last));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_OWN_MAC: mac_reg = cfg_data;
					REG_OWN_IP: ip_reg = cfg_data[31:0];
					REG_LIFETIME: life_reg = cfg_data[31:0];
					REG_TIMEOUT: tmo_reg = cfg_data[31:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				item_results.delete();
				case (in_data.cmd)
					CMD_SEND: resolve_send(in_data);
					CMD_RECV: resolve_recv(in_data);
					CMD_TICK: resolve_tick(in_data.elapsed_ms);
					default: ;
				endcase
				if (item_results.size() > 0)
					item_results[item_results.size() - 1].out_last = 1'b1;
				foreach (item_results[k]) due_results.push_back(item_results[k]);
			end
			if (run_done && !done_seen) begin
				done_seen = 1;
				if (due_results.size() != 0)
					report($sformatf("%0d results never arrived", due_results.size()));
			end
			waiting = due_results.size();
		end
	end

endmodule

`default_nettype wire

// File: tb/sv/arp_cache_with_pending_queue_tb.sv
// Testbench top for the ARP resolution cache: clock, reset, register writes,
// directed and random items, output stalls and the verdict.
// Depends on arpc_pkg, arpc_scoreboard and arp_cache_with_pending_queue.
`default_nettype none

module arp_cache_with_pending_queue_tb;
	import arpc_pkg::*;

	localparam int QUIET_CYCLES = 600;
	localparam int STALL_LIMIT  = 5000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [47:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        run_done;
	int          errors;
	int          waiting;
	int          idle_cycles;
	int          burst_left;
	int          rdy_mode;
	int          rdy_timer;
	int          rdy_hold;
	logic [31:0] ip_pool [20];

	arp_cache_with_pending_queue i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	arpc_scoreboard i_scoreboard (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.run_done(run_done), .errors(errors), .waiting(waiting)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// stall the output on a changing pattern
	always @(negedge clk) begin
		if (rdy_timer == 0) begin
			rdy_mode <= $urandom_range(0, 2);
			rdy_timer <= $urandom_range(50, 300);
		end else rdy_timer <= rdy_timer - 1;
		case (rdy_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 9) < 7);
			default: begin
				if (rdy_hold == 0) begin
					rdy_hold <= $urandom_range(1, 25);
					out_ready <= !out_ready;
				end else rdy_hold <= rdy_hold - 1;
			end
		endcase
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("arp_cache_with_pending_queue_tb: done, errors");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold the item until it is accepted
	task automatic push_item(input in_item_t it);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic pause(input int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// wait for all results, then let a silent item finish
	task automatic drain();
		pause(1);
		while (waiting != 0) @(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic paced_item(input in_item_t it);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if ($urandom_range(0, 9) < 7) pause($urandom_range(1, 12));
		end
		burst_left--;
		push_item(it);
	endtask

	function automatic in_item_t noise_item();
		in_item_t it;
		it.cmd = 2'($urandom);
		it.item_handle = 16'($urandom);
		it.gateway_ip = $urandom;
		it.ip_protocol = 8'($urandom);
		it.frame_dst_mac = 48'({$urandom, $urandom});
		it.frame_ethertype = 16'($urandom);
		it.payload_ok = 1'($urandom);
		it.arp_opcode = 16'($urandom);
		it.arp_sender_ip = $urandom;
		it.arp_sender_mac = 48'({$urandom, $urandom});
		it.arp_target_ip_in = $urandom;
		it.elapsed_ms = $urandom;
		return it;
	endfunction

	function automatic in_item_t send_item(input logic [31:0] ip, input logic [15:0] h,
			input logic [7:0] proto);
		in_item_t it;
		it = noise_item();
		it.cmd = CMD_SEND;
		it.gateway_ip = ip;
		it.item_handle = h;
		it.ip_protocol = proto;
		return it;
	endfunction

	function automatic in_item_t arp_item(input logic [47:0] dst, input logic [15:0] op,
			input logic [31:0] sip, input logic [47:0] smac, input logic [31:0] tip);
		in_item_t it;
		it = noise_item();
		it.cmd = CMD_RECV;
		it.frame_dst_mac = dst;
		it.frame_ethertype = ETH_ARP;
		it.payload_ok = 1'b1;
		it.arp_opcode = op;
		it.arp_sender_ip = sip;
		it.arp_sender_mac = smac;
		it.arp_target_ip_in = tip;
		return it;
	endfunction

	function automatic in_item_t frame_item(input logic [47:0] dst, input logic [15:0] etype,
			input logic ok);
		in_item_t it;
		it = noise_item();
		it.cmd = CMD_RECV;
		it.frame_dst_mac = dst;
		it.frame_ethertype = etype;
		it.payload_ok = ok;
		return it;
	endfunction

	function automatic in_item_t tick_item(input logic [31:0] el);
		in_item_t it;
		it = noise_item();
		it.cmd = CMD_TICK;
		it.elapsed_ms = el;
		return it;
	endfunction

	function automatic logic [31:0] pick_ip(input logic [31:0] own);
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return ip_pool[$urandom_range(0, 19)];
		if (r < 85) return own;
		return $urandom;
	endfunction

	function automatic logic [47:0] pick_dst(input logic [47:0] own);
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) return BROADCAST_MAC;
		if (r < 8) return own;
		return 48'({$urandom, $urandom});
	endfunction

	function automatic in_item_t random_item(input logic [47:0] mac, input logic [31:0] ip);
		in_item_t it;
		int r;
		logic [15:0] op;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			it = send_item(pick_ip(ip), 16'($urandom),
				($urandom_range(0, 9) == 0) ? 8'($urandom) : TCP_PROTOCOL);
		end else if (r < 75) begin
			case ($urandom_range(0, 9))
				0: op = 16'($urandom);
				1, 2, 3, 4: op = OP_REPLY;
				default: op = OP_REQUEST;
			endcase
			it = arp_item(pick_dst(mac), op, pick_ip(ip), 48'({$urandom, $urandom}),
				($urandom_range(0, 1) == 1) ? ip : pick_ip(ip));
			if ($urandom_range(0, 19) == 0) it.payload_ok = 1'b0;
			if ($urandom_range(0, 19) == 0) it.frame_ethertype = 16'($urandom);
		end else if (r < 85) begin
			it = frame_item(pick_dst(mac), ETH_IPV4, $urandom_range(0, 9) != 0);
		end else if (r < 95) begin
			case ($urandom_range(0, 19))
				0: it = tick_item('0);
				1: it = tick_item('1);
				2: it = tick_item($urandom);
				default: it = tick_item($urandom_range(0, 3000));
			endcase
		end else it = noise_item();
		return it;
	endfunction

	task automatic random_phase(input logic [47:0] mac, input logic [31:0] ip,
			input logic [31:0] life, input logic [31:0] tmo, input int n);
		drain();
		write_reg(REG_OWN_MAC, mac);
		write_reg(REG_OWN_IP, {16'h0, ip});
		write_reg(REG_LIFETIME, {16'h0, life});
		write_reg(REG_TIMEOUT, {16'h0, tmo});
		for (int k = 0; k < n; k++) begin
			// hold off once mid-phase until every result is back
			if (k == n / 2) begin
				pause(1);
				while (waiting != 0) @(negedge clk);
			end
			paced_item(random_item(mac, ip));
		end
	endtask

	initial begin
		logic [47:0] my_mac;
		logic [31:0] my_ip;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_OWN_MAC;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b1;
		run_done = 1'b0;
		idle_cycles = 0;
		burst_left = 0;
		rdy_mode = 0;
		rdy_timer = 0;
		rdy_hold = 0;
		foreach (ip_pool[i]) ip_pool[i] = $urandom;
		ip_pool[0] = '0;
		ip_pool[1] = '1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: basic resolution flow
		my_mac = 48'h0200_0000_0001;
		my_ip = 32'h0A00_0001;
		write_reg(REG_OWN_MAC, my_mac);
		write_reg(REG_OWN_IP, {16'h0, my_ip});
		push_item(send_item(ip_pool[2], 16'h1234, 8'd17));
		push_item(send_item(ip_pool[2], 16'h0000, TCP_PROTOCOL));
		push_item(send_item(ip_pool[2], 16'hFFFF, TCP_PROTOCOL));
		push_item(arp_item(BROADCAST_MAC, OP_REQUEST, ip_pool[2], 48'hFFFF_FFFF_FFFE, my_ip));
		push_item(send_item(ip_pool[2], 16'h5A5A, TCP_PROTOCOL));
		push_item(frame_item(my_mac, ETH_IPV4, 1'b1));
		push_item(frame_item(my_mac, ETH_IPV4, 1'b0));
		push_item(frame_item(48'h0200_0000_0002, ETH_IPV4, 1'b1));
		push_item(frame_item(BROADCAST_MAC, 16'h86DD, 1'b1));
		push_item(arp_item(my_mac, OP_REPLY, ip_pool[0], 48'h0, ip_pool[3]));
		push_item(arp_item(my_mac, 16'hFFFF, ip_pool[1], 48'h1, my_ip));
		begin
			in_item_t odd;
			odd = noise_item();
			odd.cmd = CMD_RSVD;
			push_item(odd);
		end
		push_item(tick_item('0));
		push_item(tick_item('1));
		// fill the request table, then one new address too many
		for (int k = 0; k < 9; k++)
			push_item(send_item(ip_pool[4 + k], 16'(k), TCP_PROTOCOL));
		// fill the pending list, then one handle too many
		for (int k = 0; k < 9; k++)
			push_item(send_item(ip_pool[4 + k], 16'(16'h100 + k), TCP_PROTOCOL));
		push_item(tick_item('1));

		// random phases at extreme and ordinary settings
		random_phase('0, '0, 32'd1, '1, 97);
		random_phase('1, '1, '1, 32'd1, 97);
		random_phase(48'({$urandom, $urandom}), $urandom, $urandom_range(100, 5000),
			$urandom_range(50, 2000), 97);
		random_phase(my_mac, my_ip, LIFETIME_RST, TIMEOUT_RST, 97);

		drain();
		@(negedge clk);
		run_done <= 1'b1;
		repeat (2) @(negedge clk);
		if (errors == 0) begin
			$display("arp_cache_with_pending_queue_tb: done, clean");
		end else begin
			$display("arp_cache_with_pending_queue_tb: done, errors");
		end
		$finish;
	end

endmodule

`default_nettype wire
